FILE: hw/rtl/ellc_pkg.sv
// ----------------------------------------------------------------------------
// ellc_pkg
// shared widths, codes, controller states and control structs of the
// dense to ellpack converter
// ----------------------------------------------------------------------------
package ellc_pkg;

    // fixed field widths of the channels
    localparam int ACT_W      = 2;
    localparam int ELEM_W     = 32;
    localparam int ROWSEL_W   = 6;
    localparam int SLOT_W     = 6;
    localparam int COLIDX_W   = 6;
    localparam int STATUS_W   = 2;
    localparam int MAXNZ_W    = 7;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

    // slot status codes
    localparam logic [STATUS_W-1:0] ST_STORED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PADDING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BEYOND  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd1;

    // reset value of both size registers
    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COUNT,
        S_FINISH
    } t_ctrl_state;

    typedef struct packed {
        logic capture;  // latch item, read row counter, update load position
        logic decide;   // count known: write entry or read packed store
        logic emit;     // load the result register
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free; // result register empty or being drained
    } t_dp_status;

endpackage

FILE: hw/rtl/ellc_if.sv
// ----------------------------------------------------------------------------
// ellc channel interfaces
// item, result and configuration write channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface ellc_in_if;
    logic                               valid;
    logic                               ready;
    logic [ellc_pkg::ACT_W-1:0]         action;
    logic signed [ellc_pkg::ELEM_W-1:0] element_value;
    logic [ellc_pkg::ROWSEL_W-1:0]      read_row;
    logic [ellc_pkg::SLOT_W-1:0]        read_slot;

    modport source (output valid, action, element_value, read_row, read_slot,
                    input ready);
    modport sink   (input valid, action, element_value, read_row, read_slot,
                    output ready);
endinterface

interface ellc_out_if;
    logic                               valid;
    logic                               ready;
    logic [ellc_pkg::COLIDX_W-1:0]      column_index;
    logic signed [ellc_pkg::ELEM_W-1:0] entry_value;
    logic [ellc_pkg::STATUS_W-1:0]      slot_status;
    logic [ellc_pkg::MAXNZ_W-1:0]       max_nonzeros;
    logic                               load_complete;

    modport source (output valid, column_index, entry_value, slot_status,
                    max_nonzeros, load_complete, input ready);
    modport sink   (input valid, column_index, entry_value, slot_status,
                    max_nonzeros, load_complete, output ready);
endinterface

interface ellc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ellc_pkg::CFG_IDX_W-1:0] index;
    logic [ellc_pkg::CFG_W-1:0]     wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

FILE: hw/rtl/dense_to_ellpack_converter.sv
// ----------------------------------------------------------------------------
// dense_to_ellpack_converter
// packs a row-major dense integer matrix into ellpack column/value slots
// and answers slot reads with stored entries, padding or a beyond flag
// ----------------------------------------------------------------------------
//
// channel    dir  handshake      carries
// i_in_ch    in   valid/ready    action, element_value, read_row, read_slot
// o_out_ch   out  valid/ready    column_index, entry_value, slot_status,
//                                max_nonzeros, load_complete
// i_cfg_ch   in   valid/ready    index (0 rows_in_use, 1 cols_in_use), wdata
//
// every item steps through capture with the row counter memory read,
// count decision with the packed store read or write, then the result
// register load; the single-port row counter and packed store set this
// order. the next item is taken the cycle after its result is loaded.
// reset is synchronous, active low, and clears counts and load position
// at once through per-row valid bits; no clearing pass.
// a stalled result holds in the output register; the block then finishes
// one more item and waits with it until the register drains.
// configuration writes are taken in any cycle (ready is held high).
//
module dense_to_ellpack_converter #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ellc_in_if.sink     i_in_ch,
    ellc_out_if.source  o_out_ch,
    ellc_cfg_if.sink    i_cfg_ch
);
    import ellc_pkg::*;

    // command and status between sequencer and datapath
    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    // sequencer: owns the item handshake, steps one item at a time
    ellc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (i_in_ch),
        .o_cmd    (ctrl_cmd),
        .i_status (dp_status)
    );

    // datapath: size registers, row counters, packed store, result register
    ellc_datapath #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_action        (i_in_ch.action),
        .i_element_value (i_in_ch.element_value),
        .i_read_row      (i_in_ch.read_row),
        .i_read_slot     (i_in_ch.read_slot),
        .o_out_ch        (o_out_ch),
        .i_cfg_ch        (i_cfg_ch),
        .i_cmd           (ctrl_cmd),
        .o_status        (dp_status)
    );

endmodule

FILE: hw/rtl/ellc_ctrl.sv
// ----------------------------------------------------------------------------
// ellc_ctrl
// sequencer: one item at a time through count read, decision and result
// ----------------------------------------------------------------------------
module ellc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ellc_in_if.sink               i_in_ch,
    output ellc_pkg::t_ctrl_cmd   o_cmd,
    input  ellc_pkg::t_dp_status  i_status
);
    import ellc_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_ch.valid) n_state = S_COUNT;
            end
            S_COUNT: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        in_ready      = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.decide  = 1'b0;
        o_cmd.emit    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_ready      = 1'b1;
                o_cmd.capture = i_in_ch.valid;
            end
            S_COUNT: begin
                o_cmd.decide = 1'b1;
            end
            S_FINISH: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign i_in_ch.ready = in_ready;

endmodule

FILE: hw/rtl/ellc_datapath.sv
// ----------------------------------------------------------------------------
// ellc_datapath
// size registers, load position, row counters, packed column/value store
// and the result register
// ----------------------------------------------------------------------------
module ellc_datapath #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [ellc_pkg::ACT_W-1:0]         i_action,
    input  logic signed [ellc_pkg::ELEM_W-1:0] i_element_value,
    input  logic [ellc_pkg::ROWSEL_W-1:0]      i_read_row,
    input  logic [ellc_pkg::SLOT_W-1:0]        i_read_slot,
    ellc_out_if.source                         o_out_ch,
    ellc_cfg_if.sink                           i_cfg_ch,
    input  ellc_pkg::t_ctrl_cmd                i_cmd,
    output ellc_pkg::t_dp_status               o_status
);
    import ellc_pkg::*;

    localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W       = $clog2(MAX_COLS + 1);
    localparam int ROWS_DEPTH  = 1 << ROW_W;
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int RPOS_W      = $clog2(MAX_ROWS + 1);
    localparam int CPOS_W      = $clog2(MAX_COLS + 1);
    localparam int POS_A       = (RPOS_W > CPOS_W) ? RPOS_W : CPOS_W;
    localparam int POS_W       = ((POS_A > CFG_W) ? POS_A : CFG_W) + 1;
    localparam int VEXT_W      = (VALUE_BITS > ELEM_W) ? VALUE_BITS : ELEM_W;
    localparam int CEXT_W      = (COL_W > COLIDX_W) ? COL_W : COLIDX_W;
    localparam int MEXT_W      = (CNT_W > MAXNZ_W) ? CNT_W : MAXNZ_W;
    localparam int REXT_W      = (ROW_W > ROWSEL_W) ? ROW_W : ROWSEL_W;

    // size registers
    logic [CFG_W-1:0] r_rows_in_use;
    logic [CFG_W-1:0] r_cols_in_use;

    // load position and summary state
    logic [POS_W-1:0] r_load_row;
    logic [POS_W-1:0] r_load_col;
    logic             r_all_loaded;
    logic [CNT_W-1:0] r_largest;
    logic [ROWS_DEPTH-1:0] r_count_vld;

    // memories
    logic [CNT_W-1:0]      m_count [ROWS_DEPTH];
    logic [COL_W-1:0]      m_cols  [STORE_DEPTH];
    logic [VALUE_BITS-1:0] m_vals  [STORE_DEPTH];

    // captured item
    logic [ACT_W-1:0]      r_act;
    logic [VALUE_BITS-1:0] r_value;
    logic [ROW_W-1:0]      r_row;
    logic [COL_W-1:0]      r_col;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_row_ok;
    logic                  r_ld_go;
    logic [CNT_W-1:0]      r_count_q;

    // read decision
    logic [STATUS_W-1:0]   r_status;
    logic                  r_col_need;
    logic                  r_val_need;
    logic [COL_W-1:0]      r_pk_col_q;
    logic [VALUE_BITS-1:0] r_pk_val_q;

    // result register
    logic                  r_out_valid;
    logic [COLIDX_W-1:0]   r_out_col;
    logic [ELEM_W-1:0]     r_out_val;
    logic [STATUS_W-1:0]   r_out_status;
    logic [MAXNZ_W-1:0]    r_out_max;
    logic                  r_out_done;

    // clamped sizes
    logic [POS_W-1:0] rows_eff;
    logic [POS_W-1:0] cols_eff;

    always_comb begin
        rows_eff = POS_W'(r_rows_in_use);
        if (rows_eff == '0) begin
            rows_eff = POS_W'(1);
        end else if (rows_eff > POS_W'(MAX_ROWS)) begin
            rows_eff = POS_W'(MAX_ROWS);
        end
        cols_eff = POS_W'(r_cols_in_use);
        if (cols_eff == '0) begin
            cols_eff = POS_W'(1);
        end else if (cols_eff > POS_W'(MAX_COLS)) begin
            cols_eff = POS_W'(MAX_COLS);
        end
    end

    // load position seen by this item
    logic [POS_W-1:0]      ld_row0;
    logic [POS_W-1:0]      ld_col0;
    logic [POS_W-1:0]      ld_col_inc;
    logic [POS_W-1:0]      ld_row_inc;
    logic                  ld_active;
    logic [VEXT_W-1:0]     elem_ext;
    logic [VALUE_BITS-1:0] elem_val;
    logic [REXT_W-1:0]     rsel_ext;
    logic                  rsel_ok;
    logic [ROW_W-1:0]      cnt_addr;

    always_comb begin
        if (r_load_col >= cols_eff) begin
            ld_col0 = '0;
            ld_row0 = r_load_row + POS_W'(1);
        end else begin
            ld_col0 = r_load_col;
            ld_row0 = r_load_row;
        end
        ld_col_inc = ld_col0 + POS_W'(1);
        ld_row_inc = ld_row0 + POS_W'(1);
        ld_active  = !r_all_loaded && (ld_row0 < rows_eff);
        elem_ext   = VEXT_W'($unsigned(i_element_value));
        elem_val   = elem_ext[VALUE_BITS-1:0];
        rsel_ext   = REXT_W'(i_read_row);
        rsel_ok    = POS_W'(i_read_row) < POS_W'(MAX_ROWS);
        unique case (i_action)
            ACT_LOAD: cnt_addr = ld_row0[ROW_W-1:0];
            default:  cnt_addr = rsel_ext[ROW_W-1:0];
        endcase
    end

    // decision on the row count
    logic [CNT_W-1:0]    cur_count;
    logic [CNT_W-1:0]    count_inc;
    logic                store_go;
    logic [POS_W-1:0]    slot_ext;
    logic [POS_W-1:0]    count_ext;
    logic [POS_W-1:0]    pad_idx;
    logic [COL_W-1:0]    slot_addr;
    logic [STATUS_W-1:0] status_d;
    logic                col_need_d;
    logic                val_need_d;

    always_comb begin
        cur_count  = (r_count_vld[r_row] && r_row_ok) ? r_count_q : '0;
        count_inc  = cur_count + CNT_W'(1);
        store_go   = r_ld_go && (cur_count < CNT_W'(MAX_COLS));
        slot_ext   = POS_W'(r_slot);
        count_ext  = POS_W'(cur_count);
        pad_idx    = count_ext - POS_W'(1);
        slot_addr  = slot_ext[COL_W-1:0];
        status_d   = ST_STORED;
        col_need_d = 1'b0;
        val_need_d = 1'b0;
        if (r_act == ACT_READ) begin
            if (slot_ext >= POS_W'(r_largest)) begin
                status_d = ST_BEYOND;
            end else if (slot_ext < count_ext) begin
                col_need_d = 1'b1;
                val_need_d = 1'b1;
            end else begin
                status_d   = ST_PADDING;
                col_need_d = cur_count != '0;
                slot_addr  = pad_idx[COL_W-1:0];
            end
        end
    end

    // configuration writes
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= CFG_SIZE_RESET;
            r_cols_in_use <= CFG_SIZE_RESET;
        end else if (i_cfg_ch.valid) begin
            unique case (i_cfg_ch.index)
                REG_ROWS_IN_USE: r_rows_in_use <= i_cfg_ch.wdata;
                REG_COLS_IN_USE: r_cols_in_use <= i_cfg_ch.wdata;
                default: begin
                    r_rows_in_use <= r_rows_in_use;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_row   <= '0;
            r_load_col   <= '0;
            r_all_loaded <= 1'b0;
            r_largest    <= '0;
            r_count_vld  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                if (i_action == ACT_RESTART) begin
                    r_load_row   <= '0;
                    r_load_col   <= '0;
                    r_all_loaded <= 1'b0;
                    r_largest    <= '0;
                    r_count_vld  <= '0;
                end else if (i_action == ACT_LOAD && !r_all_loaded) begin
                    if (ld_row0 >= rows_eff) begin
                        r_all_loaded <= 1'b1;
                        r_load_row   <= ld_row0;
                        r_load_col   <= ld_col0;
                    end else if (ld_col_inc >= cols_eff) begin
                        if (ld_row_inc >= rows_eff) begin
                            r_all_loaded <= 1'b1;
                            r_load_row   <= ld_row0;
                            r_load_col   <= ld_col_inc;
                        end else begin
                            r_load_row <= ld_row_inc;
                            r_load_col <= '0;
                        end
                    end else begin
                        r_load_row <= ld_row0;
                        r_load_col <= ld_col_inc;
                    end
                end
            end
            if (i_cmd.decide && store_go) begin
                r_count_vld[r_row] <= 1'b1;
                if (count_inc > r_largest) r_largest <= count_inc;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item capture and decision payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act    <= i_action;
            r_value  <= elem_val;
            r_slot   <= i_read_slot;
            r_col    <= ld_col0[COL_W-1:0];
            r_ld_go  <= (i_action == ACT_LOAD) && ld_active && (elem_val != '0);
            r_row_ok <= (i_action == ACT_READ) ? rsel_ok : 1'b1;
            unique case (i_action)
                ACT_LOAD: r_row <= ld_row0[ROW_W-1:0];
                default:  r_row <= rsel_ext[ROW_W-1:0];
            endcase
        end
        if (i_cmd.decide) begin
            r_status   <= status_d;
            r_col_need <= col_need_d;
            r_val_need <= val_need_d;
        end
    end

    // row counter memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_count_q <= m_count[cnt_addr];
        if (i_cmd.decide && store_go) m_count[r_row] <= count_inc;
    end

    // packed store, row-major with a row pitch of 2**COL_W
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            if (store_go) begin
                m_cols[{r_row, cur_count[COL_W-1:0]}] <= r_col;
                m_vals[{r_row, cur_count[COL_W-1:0]}] <= r_value;
            end
            if (r_act == ACT_READ) begin
                r_pk_col_q <= m_cols[{r_row, slot_addr}];
                r_pk_val_q <= m_vals[{r_row, slot_addr}];
            end
        end
    end

    // result register
    logic [CEXT_W-1:0] pk_col_ext;
    logic [VEXT_W-1:0] pk_val_ext;
    logic [MEXT_W-1:0] largest_ext;

    assign pk_col_ext  = CEXT_W'(r_pk_col_q);
    assign pk_val_ext  = VEXT_W'(r_pk_val_q);
    assign largest_ext = MEXT_W'(r_largest);

    // summary fields are frozen with the rest of the result, since the
    // next item may already move them while this one waits
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_col    <= r_col_need ? pk_col_ext[COLIDX_W-1:0] : '0;
            r_out_val    <= r_val_need ? pk_val_ext[ELEM_W-1:0] : '0;
            r_out_status <= r_status;
            r_out_max    <= largest_ext[MAXNZ_W-1:0];
            r_out_done   <= r_all_loaded;
        end
    end

    assign o_out_ch.valid         = r_out_valid;
    assign o_out_ch.column_index  = r_out_col;
    assign o_out_ch.entry_value   = r_out_val;
    assign o_out_ch.slot_status   = r_out_status;
    assign o_out_ch.max_nonzeros  = r_out_max;
    assign o_out_ch.load_complete = r_out_done;

    assign o_status.out_free = !r_out_valid || o_out_ch.ready;

endmodule
